// ----- hdl/cauchy_score_bisection_root_macros.svh -----
// assertion macros for the bisection root finder
`ifndef CAUCHY_SCORE_BISECTION_ROOT_MACROS_SVH
`define CAUCHY_SCORE_BISECTION_ROOT_MACROS_SVH

// same-cycle implication
`define CSBR_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("csbr same-cycle check failed");

// next-cycle implication
`define CSBR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("csbr next-cycle check failed");

`endif

// ----- hdl/csbr_pkg.sv -----
package csbr_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int ITER_LIMIT      = 2000;
    localparam int SUM_W           = 48;
    localparam int ITER_W          = 12;

    localparam logic [1:0] ST_CONV  = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam logic [1:0] REG_LEFT  = 2'd0;
    localparam logic [1:0] REG_RIGHT = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;

    localparam logic signed [31:0] LEFT_RST  = -32'sd655360;
    localparam logic signed [31:0] RIGHT_RST = 32'sd655360;
    localparam logic [30:0]        TOL_RST   = 31'd66;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               is_last;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] root;
        logic [10:0]        iterations;
        logic [1:0]         status;
    } out_word_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] term;
    } term_stat_t;

endpackage

// ----- hdl/cauchy_score_bisection_root.sv -----
// each score term runs through one shared square and bit-per-cycle divider (33 steps)
// throughput: sample words load one per cycle; one search at a time, not ready while busy
// reset: asynchronous active low; config registers return to defaults, sample count to zero
// sample memory contents are undefined after reset
module cauchy_score_bisection_root #(
    parameter int MAX_SAMPLES = csbr_pkg::MAX_SAMPLES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  csbr_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output csbr_pkg::out_word_t  out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import csbr_pkg::*;

    `include "cauchy_score_bisection_root_macros.svh"

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_LAT   = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_EVAL  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]               state_reg;
    logic signed [31:0]       left_reg;
    logic signed [31:0]       right_reg;
    logic [30:0]              tol_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            idx_reg;
    logic signed [31:0]       low_reg;
    logic signed [31:0]       high_reg;
    logic signed [31:0]       mid_reg;
    logic signed [31:0]       theta_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic                     phase_low_reg;
    logic                     sign_mid_reg;
    logic [1:0]               status_reg;
    logic                     out_valid_reg;
    out_word_t                out_reg;

    logic                     in_fire;
    logic                     cfg_wr;
    logic                     store_we;
    logic                     out_load;
    logic [31:0]              rdata;
    logic signed [32:0]       d;
    logic                     term_start;
    term_stat_t               tstat;
    logic signed [32:0]       width;
    logic signed [32:0]       pair_sum;
    logic signed [31:0]       mid_c;
    logic                     opposite;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign store_we   = in_fire && (count_reg < CW'(MAX_SAMPLES));
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign d          = {rdata[31], rdata} - {theta_reg[31], theta_reg};
    assign term_start = (state_reg == S_LAT);
    assign width      = {high_reg[31], high_reg} - {low_reg[31], low_reg};
    assign pair_sum   = {high_reg[31], high_reg} + {low_reg[31], low_reg};
    assign mid_c      = pair_sum[32:1];
    assign opposite   = (acc_reg != '0) && (acc_reg[SUM_W-1] != sign_mid_reg);

    csbr_store #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .AW          (AW)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_word.sample),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    csbr_term u_term (
        .clk   (clk),
        .rst_n (rst_n),
        .start (term_start),
        .d     (d),
        .stat  (tstat)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= LEFT_RST;
            right_reg <= RIGHT_RST;
            tol_reg   <= TOL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_LEFT:  left_reg  <= pwdata;
                REG_RIGHT: right_reg <= pwdata;
                REG_TOL:   tol_reg   <= pwdata[30:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LEFT:  prdata = left_reg;
            REG_RIGHT: prdata = right_reg;
            REG_TOL:   prdata = {1'b0, tol_reg};
            default:   prdata = '0;
        endcase
    end

    // search sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            mid_reg       <= '0;
            theta_reg     <= '0;
            iter_reg      <= '0;
            acc_reg       <= '0;
            phase_low_reg <= 1'b0;
            sign_mid_reg  <= 1'b0;
            status_reg    <= ST_CONV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (store_we)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        if (in_word.is_last)
                        begin
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    low_reg  <= left_reg;
                    high_reg <= right_reg;
                    mid_reg  <= '0;
                    if (left_reg >= right_reg)
                    begin
                        iter_reg   <= '0;
                        status_reg <= ST_BAD;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        iter_reg  <= ITER_W'(1);
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (width <= $signed({2'b00, tol_reg}))
                    begin
                        status_reg <= ST_CONV;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        mid_reg       <= mid_c;
                        theta_reg     <= mid_c;
                        phase_low_reg <= 1'b0;
                        acc_reg       <= '0;
                        idx_reg       <= '0;
                        state_reg     <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_LAT;
                end
                S_LAT:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (tstat.done)
                    begin
                        acc_reg <= acc_reg + SUM_W'(tstat.term);
                        idx_reg <= idx_reg + CW'(1);
                        if (idx_reg + CW'(1) == count_reg)
                        begin
                            state_reg <= S_EVAL;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_EVAL:
                begin
                    if (!phase_low_reg)
                    begin
                        if (acc_reg == '0)
                        begin
                            status_reg <= ST_ZERO;
                            state_reg  <= S_OUT;
                        end
                        else if (iter_reg > ITER_W'(ITER_LIMIT))
                        begin
                            status_reg <= ST_LIMIT;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            sign_mid_reg  <= acc_reg[SUM_W-1];
                            theta_reg     <= low_reg;
                            phase_low_reg <= 1'b1;
                            acc_reg       <= '0;
                            idx_reg       <= '0;
                            state_reg     <= S_RD;
                        end
                    end
                    else
                    begin
                        if (opposite)
                        begin
                            high_reg <= mid_reg;
                        end
                        else
                        begin
                            low_reg <= mid_reg;
                        end
                        iter_reg  <= iter_reg + ITER_W'(1);
                        state_reg <= S_CHECK;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        count_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.root       <= mid_reg;
            out_reg.iterations <= iter_reg[10:0];
            out_reg.status     <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    `CSBR_ASSERT_NOW(a_bad_no_iter, out_valid_reg && out_reg.status == ST_BAD, out_reg.iterations == 11'd0)
    `CSBR_ASSERT_NOW(a_iter_bound, 1'b1, iter_reg <= ITER_W'(ITER_LIMIT + 1))
    `CSBR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_SAMPLES))
    `CSBR_ASSERT_NOW(a_term_when_waiting, tstat.done, state_reg == S_WAIT)

endmodule

// ----- hdl/csbr_store.sv -----
module csbr_store #(
    parameter int MAX_SAMPLES = 1024,
    parameter int AW          = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [31:0]       wdata,
    input  logic [AW-1:0]     raddr,
    output logic [31:0]       rdata
);
    import csbr_pkg::*;

    logic [31:0] mem [MAX_SAMPLES];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/csbr_term.sv -----
module csbr_term (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [32:0]    d,
    output csbr_pkg::term_stat_t  stat
);
    import csbr_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_SQ   = 2'd1;
    localparam logic [1:0] T_DIV  = 2'd2;
    localparam logic [1:0] T_DONE = 2'd3;

    logic [1:0]  state_reg;
    logic [5:0]  cnt_reg;
    logic [30:0] m_reg;
    logic        neg_reg;
    logic [62:0] den_reg;
    logic [63:0] r_reg;
    logic [32:0] q_reg;

    logic [32:0] d_abs;
    logic [30:0] m_next;
    logic [61:0] sq;
    logic [63:0] r_sh;
    logic        fit;

    assign d_abs  = d[32] ? 33'(-d) : 33'(d);
    assign m_next = (d_abs > 33'h07FFFFFFF) ? 31'h7FFFFFFF : d_abs[30:0];
    assign sq     = 62'(m_reg) * 62'(m_reg);
    assign r_sh   = {r_reg[62:0], 1'b0};
    assign fit    = r_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= T_SQ;
                    end
                end
                T_SQ:
                begin
                    cnt_reg   <= '0;
                    state_reg <= T_DIV;
                end
                T_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd32)
                    begin
                        state_reg <= T_DONE;
                    end
                end
                T_DONE:
                begin
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_IDLE && start)
        begin
            m_reg   <= m_next;
            neg_reg <= d[32];
        end
        if (state_reg == T_SQ)
        begin
            den_reg <= (63'd1 << 32) + {1'b0, sq};
            r_reg   <= {33'd0, m_reg};
            q_reg   <= '0;
        end
        if (state_reg == T_DIV)
        begin
            r_reg <= fit ? (r_sh - {1'b0, den_reg}) : r_sh;
            q_reg <= {q_reg[31:0], fit};
        end
    end

    assign stat.done = (state_reg == T_DONE);
    assign stat.term = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

// ----- test/cauchy_score_bisection_root_tb.sv -----
`timescale 1ns / 100ps

module cauchy_score_bisection_root_tb;
    import csbr_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int STORE_DEPTH = 1024;

    class root_scoreboard;
        logic signed [31:0] samples [STORE_DEPTH];
        int unsigned        held;
        logic signed [31:0] left_end;
        logic signed [31:0] right_end;
        logic [30:0]        tolerance;
        out_word_t          expected_q [$];
        int                 errors;

        function new();
            held = 0;
            errors = 0;
            left_end = LEFT_RST;
            right_end = RIGHT_RST;
            tolerance = TOL_RST;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == REG_LEFT)
                left_end = val;
            else if (idx == REG_RIGHT)
                right_end = val;
            else if (idx == REG_TOL)
                tolerance = val[30:0];
        endfunction

        function longint term_of(longint d);
            longint unsigned m;
            longint unsigned den;
            longint unsigned q;
            m = (d < 0) ? longint'(-d) : longint'(d);
            if (m > 64'h7FFF_FFFF)
                m = 64'h7FFF_FFFF;
            den = 64'h1_0000_0000 + m * m;
            q = (m << 33) / den;
            return (d < 0) ? -longint'(q) : longint'(q);
        endfunction

        function longint score_sum_at(longint theta);
            longint s;
            s = 0;
            for (int i = 0; i < held; i++)
                s += term_of(longint'(samples[i]) - theta);
            return s;
        endfunction

        function int sign_of(longint v);
            return (v > 0) - (v < 0);
        endfunction

        function out_word_t bisect();
            out_word_t r;
            longint lo;
            longint hi;
            longint mid;
            longint s;
            int     iter;
            logic [1:0] st;
            lo = longint'(left_end);
            hi = longint'(right_end);
            mid = 0;
            st = ST_CONV;
            if (lo >= hi) begin
                iter = 0;
                st = ST_BAD;
            end else begin
                iter = 1;
                while (hi - lo > longint'(tolerance)) begin
                    mid = (lo + hi) >>> 1;
                    s = score_sum_at(mid);
                    if (s == 0) begin
                        st = ST_ZERO;
                        break;
                    end
                    if (iter > ITER_LIMIT) begin
                        st = ST_LIMIT;
                        break;
                    end
                    if (sign_of(s) * sign_of(score_sum_at(lo)) < 0)
                        hi = mid;
                    else
                        lo = mid;
                    iter++;
                end
            end
            r.root = mid[31:0];
            r.iterations = iter[10:0];
            r.status = st;
            return r;
        endfunction

        function void note_input(in_word_t w);
            if (held < STORE_DEPTH) begin
                samples[held] = w.sample;
                held++;
            end
            if (w.is_last) begin
                expected_q.push_back(bisect());
                held = 0;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0) begin
                report("unexpected word", got.root, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.root !== want.root)
                report("root", got.root, want.root);
            if (got.iterations !== want.iterations)
                report("iterations", got.iterations, want.iterations);
            if (got.status !== want.status)
                report("status", got.status, want.status);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    root_scoreboard sb;
    bit             idle_on;
    int             stall_left;
    int             cycles;

    cauchy_score_bisection_root dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_word);
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task set_interval(logic [31:0] lo, logic [31:0] hi, logic [31:0] tol);
        reg_write(REG_LEFT, lo);
        reg_write(REG_RIGHT, hi);
        reg_write(REG_TOL, tol);
    endtask

    task send_sample(logic [31:0] s, logic last);
        in_word_t w;
        w.sample = s;
        w.is_last = last;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(w);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function logic [31:0] near_sample();
        int v;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        v = $urandom_range(0, 32 << 16);
        return v - (16 << 16);
    endfunction

    task random_phase(int items);
        longint lo;
        longint hi;
        longint width;
        int     pick;
        int     n;
        pick = $urandom_range(0, 5);
        if (pick == 0)
        begin
            lo = -64'sd2147483648;
            hi = 64'sd2147483647;
        end
        else if (pick == 1)
        begin
            lo = $signed($urandom);
            hi = $signed($urandom);
        end
        else
        begin
            lo = -longint'($urandom_range(1, 40 << 16));
            hi = longint'($urandom_range(0, 40 << 16));
        end
        width = (hi > lo) ? hi - lo : 1;
        set_interval(lo[31:0], hi[31:0], 32'(width >> $urandom_range(6, 18)));
        while (items > 0)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_sample(near_sample(), i == n - 1);
            items -= n;
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_on = 1'b1;
        stall_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // defaults after reset, field extremes, exact zero score
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0, 1'b0);
        send_sample(32'h0001_8000, 1'b1);
        send_sample(32'h0002_0000, 1'b1);
        send_sample(32'h0003_0000, 1'b0);
        send_sample(-32'sh0003_0000, 1'b1);
        drain();

        // bad interval, equal and reversed ends
        set_interval(32'h0005_0000, 32'h0005_0000, 32'd66);
        send_sample(32'h0001_0000, 1'b1);
        drain();
        set_interval(32'h0006_0000, -32'sh0006_0000, 32'd66);
        send_sample(32'h0001_0000, 1'b1);
        drain();

        // width within tolerance from the start
        set_interval(32'd0, 32'd100, 32'd100);
        send_sample(32'h0007_0000, 1'b1);
        drain();

        // width of one above tolerance runs into the limit
        set_interval(32'd0, 32'd1, 32'd0);
        send_sample(32'h0005_0000, 1'b1);
        drain();

        // full range with zero and maximum tolerance
        set_interval(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'd12345, 1'b1);
        drain();
        set_interval(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'hFFFF_0000, 1'b1);
        drain();

        // spare address leaves the registers alone
        set_interval(-32'sh000A_0000, 32'h000A_0000, 32'd66);
        reg_write(REG_SPARE, 32'h1234_5678);
        send_sample(32'h0002_4000, 1'b0);
        send_sample(-32'sh0001_0000, 1'b1);
        drain();

        // overfull batch, words past the store are dropped
        set_interval(-32'sh000A_0000, 32'h000A_0000, 32'h0013_FFFF);
        for (int i = 0; i < STORE_DEPTH + 6; i++)
        begin
            if (i < STORE_DEPTH)
                send_sample($urandom_range(0, 6 << 16), 1'b0);
            else
                send_sample(-32'sh0009_0000, i == STORE_DEPTH + 5);
        end
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                idle_on = 1'b0;
            random_phase(75);
        end

        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
